FILE: rtl/radial_exp_falloff_scale_unit_defines.svh
// ----------------------------------------------------------------------------
// Radial falloff scale unit: assertion macros
// Shared property wrappers, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RADIAL_EXP_FALLOFF_SCALE_UNIT_DEFINES_SVH
`define RADIAL_EXP_FALLOFF_SCALE_UNIT_DEFINES_SVH

// same-cycle implication
`define RXS_ASSERT_IMP(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("rxs: same-cycle check failed");

// next-cycle implication
`define RXS_ASSERT_NXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("rxs: next-cycle check failed");

`endif

FILE: rtl/rxs_pkg.sv
// ----------------------------------------------------------------------------
// Radial falloff scale package
// Types, constants and square-root helpers shared by the datapath.
// ----------------------------------------------------------------------------
package rxs_pkg;

  localparam logic [31:0] ONE_Q16   = 32'd65536;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [40:0] T_MAX     = 41'd1310720;  // 20.0 in Q16.16
  localparam logic [5:0]  N_LIMIT   = 6'd17;
  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    REG_CENTER_X      = 3'd0,
    REG_CENTER_Y      = 3'd1,
    REG_CENTER_Z      = 3'd2,
    REG_SCALE_X       = 3'd3,
    REG_SCALE_Y       = 3'd4,
    REG_SCALE_Z       = 3'd5,
    REG_FALLOFF       = 3'd6,
    REG_GLOBAL_WEIGHT = 3'd7
  } cfg_reg_t;

  // square-root iteration state: partial remainder and root
  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
  } rt_t;

  // per-item sideband carried down the whole pipe
  typedef struct packed {
    logic             last;
    logic [95:0]      pos;
    logic [2:0][32:0] d;
  } side_t;

  // one restoring square-root digit: bring in two radicand bits
  function automatic rt_t rt_step(rt_t s, logic [1:0] bits);
    logic [34:0] rem;
    logic [34:0] trial;
    rt_t         o;
    rem   = {s.rem[32:0], bits};
    trial = {1'b0, s.root, 2'b01};
    if (rem >= trial) begin
      o.rem  = rem - trial;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = rem;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [31:0] isqrt64(logic [63:0] v);
    rt_t s;
    s = '0;
    for (int i = 0; i < 32; i++) begin
      s = rt_step(s, v[63-2*i -: 2]);
    end
    return s.root;
  endfunction

  // 2^-(2^-(j+1)) in Q30
  function automatic logic [30:0] exp_coef(int j);
    logic [63:0] c;
    c = 64'(isqrt64(64'h0800_0000_0000_0000));
    for (int i = 0; i < j; i++) begin
      c = 64'(isqrt64({c[33:0], 30'b0}));
    end
    return c[30:0];
  endfunction

endpackage

FILE: rtl/radial_exp_falloff_scale_unit.sv
// ----------------------------------------------------------------------------
// Radial falloff scale unit
// Scales vertex offsets from a center by a factor blended with exp falloff.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one vertex per beat, tdata = {pos_z, pos_y, pos_x} (Q16.16),
//           tlast marks the last vertex of a buffer and is passed along.
//   out_* : one deformed vertex per beat, same packing, saturated to 32 bits.
//   cfg_* : register writes (index 0..7: center xyz, scale xyz, falloff,
//           global weight); always ready, write only while the pipe is empty.
// One vertex enters per cycle while the output side keeps taking beats. The
// depth comes from the square root (two digits per stage, 16 stages) and the
// exp product chain (one 31x31 multiply per fraction bit, 16 stages).
// All stages move together: when the output beat is held, the whole pipe
// holds and in_tready drops; nothing is lost or repeated.
// Reset empties the pipe and loads center 0, scales 1.0, falloff 1.0 and
// global weight 1.0.
// ----------------------------------------------------------------------------
`include "radial_exp_falloff_scale_unit_defines.svh"

module radial_exp_falloff_scale_unit
  import rxs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // out_x [31:0], out_y [63:32], out_z [95:64]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int ST_D   = 0;
  localparam int ST_SQ  = 1;
  localparam int ST_SUM = 2;
  localparam int ST_RT  = 3;            // 16 root stages
  localparam int ST_T   = ST_RT + 16;
  localparam int ST_Y   = ST_T + 1;
  localparam int ST_M   = ST_Y + 1;     // 16 exp product stages
  localparam int ST_E   = ST_M + 16;
  localparam int ST_W   = ST_E + 1;
  localparam int ST_KP  = ST_W + 1;
  localparam int ST_K   = ST_KP + 1;
  localparam int ST_PP  = ST_K + 1;
  localparam int ST_OUT = ST_PP + 1;
  localparam int NS     = ST_OUT + 1;

  // configuration
  logic [31:0] cen_r [3];
  logic [31:0] scl_r [3];
  logic [23:0] falloff_r;
  logic [16:0] gw_r;

  // pipe control
  logic          adv;
  logic [NS-1:0] vld_r;
  side_t         side_r [NS];
  side_t         side_in;

  // stage payloads
  logic [31:0]        a_r [3];
  logic [63:0]        sq_r [3];
  logic [63:0]        sum_r;
  rt_t                rt_r [16];
  logic [63:0]        rt_v_r [16];
  logic [40:0]        t_r;
  logic [21:0]        y_r;
  logic               yz_r;
  logic [30:0]        m_r [16];
  logic [21:0]        my_r [16];
  logic               mz_r [16];
  logic [16:0]        e_r;
  logic [16:0]        w_r;
  logic signed [50:0] kp_r [3];
  logic               kp_wz_r;
  logic signed [35:0] k_r [3];
  logic               k_wz_r;
  logic [51:0]        ph_r [3];
  logic [48:0]        pl_r [3];
  logic [2:0]         neg_r;
  logic               pp_wz_r;
  logic [95:0]        out_data_r;

  // combinational stage inputs
  logic [32:0]        mag_d [3];
  logic [56:0]        t_full;
  logic [51:0]        y_prod;
  logic [5:0]         e_n;
  logic               e_zero;
  logic [31:0]        e_sum;
  logic [33:0]        w_sum;
  logic signed [32:0] sm1 [3];
  logic signed [50:0] kp_n [3];
  logic signed [35:0] k_n [3];
  logic [32:0]        ad [3];
  logic [35:0]        ak [3];
  logic [53:0]        p_n [3];
  logic signed [55:0] r_n [3];
  logic [31:0]        sat_n [3];

  assign adv        = out_tready || !vld_r[ST_OUT];
  assign in_tready  = adv;
  assign out_tvalid = vld_r[ST_OUT];
  assign out_tdata  = out_data_r;
  assign out_tlast  = side_r[ST_OUT].last;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        cen_r[i] <= '0;
        scl_r[i] <= ONE_Q16;
      end
      falloff_r <= 24'(ONE_Q16);
      gw_r      <= 17'(ONE_Q16);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X:      cen_r[0]  <= cfg_data;
        REG_CENTER_Y:      cen_r[1]  <= cfg_data;
        REG_CENTER_Z:      cen_r[2]  <= cfg_data;
        REG_SCALE_X:       scl_r[0]  <= cfg_data;
        REG_SCALE_Y:       scl_r[1]  <= cfg_data;
        REG_SCALE_Z:       scl_r[2]  <= cfg_data;
        REG_FALLOFF:       falloff_r <= cfg_data[23:0];
        REG_GLOBAL_WEIGHT: gw_r      <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_tvalid};
    end
  end

  // offsets, magnitudes and the lane stages
  always_comb begin
    side_in.last = in_tlast;
    side_in.pos  = in_tdata;
    for (int i = 0; i < 3; i++) begin
      side_in.d[i] = {in_tdata[32*i+31], in_tdata[32*i +: 32]} - {cen_r[i][31], cen_r[i]};
      mag_d[i]     = side_in.d[i][32] ? (~side_in.d[i] + 33'd1) : side_in.d[i];
    end

    t_full = 57'({rt_r[15].root, 1'b0}) * 57'(falloff_r);
    y_prod = 52'(t_r[20:0]) * 52'(LOG2E_Q30);

    e_n    = my_r[15][21:16];
    e_zero = mz_r[15] || (e_n >= N_LIMIT);
    e_sum  = 32'(m_r[15] >> e_n[4:0]) + 32'd8192;

    w_sum  = 34'(e_r) * 34'(gw_r) + 34'd32768;

    for (int i = 0; i < 3; i++) begin
      sm1[i]  = $signed({scl_r[i][31], scl_r[i]}) - 33'sd65536;
      kp_n[i] = 51'(sm1[i]) * 51'($signed({1'b0, w_r}));
      k_n[i]  = 36'((kp_r[i] + 51'sd32768) >>> 16) + 36'sd65536;

      ad[i] = side_r[ST_K].d[i][32] ? (~side_r[ST_K].d[i] + 33'd1) : side_r[ST_K].d[i];
      ak[i] = k_r[i][35] ? 36'(-k_r[i]) : 36'(k_r[i]);

      // round the low partial product, then fold in sign and center
      p_n[i] = 54'(ph_r[i]) + 54'((50'(pl_r[i]) + 50'd32768) >> 16);
      r_n[i] = (neg_r[i] ? -$signed({2'b0, p_n[i]}) : $signed({2'b0, p_n[i]}))
               + 56'($signed(side_r[ST_PP].pos[32*i +: 32]) - $signed(side_r[ST_PP].d[i]));
      if (r_n[i] > 56'(SAT_MAX)) begin
        sat_n[i] = SAT_MAX;
      end else if (r_n[i] < 56'(SAT_MIN)) begin
        sat_n[i] = SAT_MIN;
      end else begin
        sat_n[i] = r_n[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_in;
      for (int k = 1; k < NS; k++) begin
        side_r[k] <= side_r[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        a_r[i]  <= mag_d[i][32:1];
        sq_r[i] <= 64'(a_r[i]) * 64'(a_r[i]);
        kp_r[i] <= kp_n[i];
        k_r[i]  <= k_n[i];
        ph_r[i] <= 52'(ad[i]) * 52'(ak[i][34:16]);
        pl_r[i] <= 49'(ad[i]) * 49'(ak[i][15:0]);
        neg_r[i] <= side_r[ST_K].d[i][32] ^ k_r[i][35];
        out_data_r[32*i +: 32] <= pp_wz_r ? side_r[ST_PP].pos[32*i +: 32] : sat_n[i];
      end
      sum_r   <= sq_r[0] + sq_r[1] + sq_r[2];
      t_r     <= t_full[56:16];
      y_r     <= y_prod[51:30];
      yz_r    <= (t_r >= T_MAX);
      e_r     <= e_zero ? '0 : e_sum[30:14];
      w_r     <= w_sum[32:16];
      kp_wz_r <= (w_r == '0);
      k_wz_r  <= kp_wz_r;
      pp_wz_r <= k_wz_r;
    end
  end

  // square root, two digits per stage
  for (genvar g = 0; g < 16; g++) begin : g_rt
    rt_t         s_in;
    rt_t         s_mid;
    logic [63:0] v_in;
    if (g == 0) begin : g_first
      assign s_in = '0;
      assign v_in = sum_r;
    end else begin : g_next
      assign s_in = rt_r[g-1];
      assign v_in = rt_v_r[g-1];
    end
    assign s_mid = rt_step(s_in, v_in[63:62]);
    always_ff @(posedge clk) begin
      if (adv) begin
        rt_r[g]   <= rt_step(s_mid, v_in[61:60]);
        rt_v_r[g] <= {v_in[59:0], 4'b0};
      end
    end
  end

  // 2^-f as a product of per-bit factors
  for (genvar j = 0; j < 16; j++) begin : g_exp
    localparam logic [30:0] CJ = exp_coef(j);
    logic [30:0] m_in;
    logic [21:0] y_in;
    logic        z_in;
    logic [61:0] prod;
    if (j == 0) begin : g_first
      assign m_in = ONE_Q30;
      assign y_in = y_r;
      assign z_in = yz_r;
    end else begin : g_next
      assign m_in = m_r[j-1];
      assign y_in = my_r[j-1];
      assign z_in = mz_r[j-1];
    end
    assign prod = 62'(m_in) * 62'(CJ);
    always_ff @(posedge clk) begin
      if (adv) begin
        m_r[j]  <= y_in[15-j] ? prod[60:30] : m_in;
        my_r[j] <= y_in;
        mz_r[j] <= z_in;
      end
    end
  end

  `RXS_ASSERT_IMP(a_root_rem, vld_r[ST_RT+15], rt_r[15].rem <= {2'b0, rt_r[15].root, 1'b0})
  `RXS_ASSERT_IMP(a_exp_range, vld_r[ST_E], e_r <= 17'(ONE_Q16))
  `RXS_ASSERT_NXT(a_zero_pass, adv && vld_r[ST_PP] && pp_wz_r,
                  out_tdata == $past(side_r[ST_PP].pos))

endmodule

FILE: tb/radial_exp_falloff_scale_unit_test.sv
// ----------------------------------------------------------------------------
// Radial falloff scale unit testbench
// Streams vertices through the unit under random valid/ready gaps and checks
// each deformed vertex against a fixed-point predictor of the datapath,
// across several register settings including the extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module radial_exp_falloff_scale_unit_test;
  import rxs_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } vertex_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;  // out_x [31:0], out_y [63:32], out_z [95:64]
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  radial_exp_falloff_scale_unit i_dut (.*);

  // shadow registers
  longint      cen[3];
  longint      scl[3];
  logic [63:0] fall_q;
  logic [63:0] gain_q;
  logic [63:0] exp_coef_q30[16];

  vertex_t     deformed_q[$];
  int          mismatches;
  int          sent_cnt;
  int          got_cnt;
  int          cfg_cnt;
  int          cycles;
  bit          tx_idle;
  bit          rx_idle;
  bit          hold_toggle;
  bit          hold_seen;
  int          hold_left;
  int          stall_left;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] sqrt_floor(logic [63:0] v);
    logic [63:0] r, b, x;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    x = v;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] exp_neg_q16(logic [63:0] t);
    logic [63:0] y, n, m;
    logic [15:0] f;
    if (t >= (64'd20 << 16)) return 0;
    y = (t * 64'd1549082005) >> 30;
    n = y >> 16;
    f = y[15:0];
    if (n >= 17) return 0;
    m = 64'd1 << 30;
    for (int j = 0; j < 16; j++) begin
      if (f[15-j]) m = (m * exp_coef_q30[j]) >> 30;
    end
    return ((m >> n) + 64'd8192) >> 14;
  endfunction

  function automatic logic [31:0] deform_axis(longint d, longint s, longint c, longint w);
    longint      k, r;
    logic [63:0] ad, ak, p;
    k  = (((s - 65536) * w + 32768) >>> 16) + 65536;
    ad = (d < 0) ? -d : d;
    ak = (k < 0) ? -k : k;
    p  = ad * (ak >> 16) + ((ad * (ak & 64'hFFFF) + 64'd32768) >> 16);
    r  = ((d < 0) != (k < 0)) ? -longint'(p) : longint'(p);
    r  = r + c;
    if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
    if (r < -64'sh8000_0000) r = -64'sh8000_0000;
    return r[31:0];
  endfunction

  function automatic vertex_t deform_vertex(vertex_t v);
    longint      d[3];
    logic [63:0] a[3], len, t, e, w;
    vertex_t     o;
    d[0] = longint'(v.x) - cen[0];
    d[1] = longint'(v.y) - cen[1];
    d[2] = longint'(v.z) - cen[2];
    for (int i = 0; i < 3; i++) a[i] = ((d[i] < 0) ? -d[i] : d[i]) >> 1;
    len = 2 * sqrt_floor(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
    t   = (len * fall_q) >> 16;
    e   = exp_neg_q16(t);
    w   = (e * gain_q + 64'd32768) >> 16;
    o   = v;
    if (w != 0) begin
      o.x = deform_axis(d[0], scl[0], cen[0], longint'(w));
      o.y = deform_axis(d[1], scl[1], cen[1], longint'(w));
      o.z = deform_axis(d[2], scl[2], cen[2], longint'(w));
    end
    return o;
  endfunction

  // result check
  always @(posedge clk) begin
    vertex_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got_cnt++;
      if (deformed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %h last=%b", out_tdata, out_tlast);
      end else begin
        want = deformed_q.pop_front();
        if (out_tdata[31:0] !== want.x || out_tdata[63:32] !== want.y ||
            out_tdata[95:64] !== want.z || out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want %h %h %h last=%b, got %h %h %h last=%b",
                     want.x, want.y, want.z, want.last, out_tdata[31:0],
                     out_tdata[63:32], out_tdata[95:64], out_tlast);
        end
      end
    end
  end

  // receiver: per-beat random stall plus a long hold on request
  always @(posedge clk) begin
    int rx_gap;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      stall_left <= 0;
      hold_seen  <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen  <= hold_toggle;
      hold_left  <= 400;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready && rx_idle) begin
        rx_gap     = $urandom_range(0, 19);
        stall_left <= (rx_gap > 0) ? rx_gap - 1 : 0;
        out_tready <= (rx_gap == 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_vertex(vertex_t v);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {v.z, v.y, v.x};
    in_tlast  <= v.last;
    do @(posedge clk); while (!in_tready);
    deformed_q.push_back(deform_vertex(v));
    sent_cnt++;
  endtask

  task automatic wait_empty();
    in_tvalid <= 1'b0;
    while (deformed_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_cnt++;
    case (idx)
      REG_CENTER_X:      cen[0] = longint'(signed'(val));
      REG_CENTER_Y:      cen[1] = longint'(signed'(val));
      REG_CENTER_Z:      cen[2] = longint'(signed'(val));
      REG_SCALE_X:       scl[0] = longint'(signed'(val));
      REG_SCALE_Y:       scl[1] = longint'(signed'(val));
      REG_SCALE_Z:       scl[2] = longint'(signed'(val));
      REG_FALLOFF:       fall_q = {40'd0, val[23:0]};
      REG_GLOBAL_WEIGHT: gain_q = {47'd0, val[16:0]};
      default: ;
    endcase
    // cfg_valid low between writes
    @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                           logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                           logic [31:0] fo, logic [31:0] gw);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_SCALE_Z, sz);
    write_reg(REG_FALLOFF, fo);
    write_reg(REG_GLOBAL_WEIGHT, gw);
  endtask

  function automatic vertex_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic l);
    vertex_t v;
    v.x = x; v.y = y; v.z = z; v.last = l;
    return v;
  endfunction

  // mostly near the center so the weight stays nonzero, some anywhere
  function automatic vertex_t random_vertex();
    vertex_t v;
    int      sh;
    if ($urandom_range(0, 9) < 7) begin
      sh  = $urandom_range(6, 22);
      v.x = 32'(cen[0]) + 32'($signed($urandom) >>> (31 - sh));
      v.y = 32'(cen[1]) + 32'($signed($urandom) >>> (31 - sh));
      v.z = 32'(cen[2]) + 32'($signed($urandom) >>> (31 - sh));
    end else begin
      v.x = $urandom; v.y = $urandom; v.z = $urandom;
    end
    v.last = 1'($urandom_range(0, 1));
    return v;
  endfunction

  function automatic logic [31:0] random_scale();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
      2:       return 32'h0001_0000;
      default: return 32'($signed($urandom) >>> 8);
    endcase
  endfunction

  task automatic test_defaults();
    send_vertex(mk(32'h0, 32'h0, 32'h0, 1'b0));
    send_vertex(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
    send_vertex(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000, 1'b0));
    send_vertex(mk(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 1'b1));
    wait_empty();
  endtask

  task automatic test_directed();
    // scaled neighborhood of an offset center
    write_all(32'h0064_0000, 32'hFFCE_0000, 32'h0003_0000,
              32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000, 32'h0001_0000);
    send_vertex(mk(32'h0064_0000, 32'hFFCE_0000, 32'h0003_0000, 1'b0));
    send_vertex(mk(32'h0065_0000, 32'hFFCF_8000, 32'h0002_0000, 1'b1));
    send_vertex(mk(32'h0066_4000, 32'hFFCD_0000, 32'h0004_0000, 1'b0));
    send_vertex(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    wait_empty();
    // zero falloff, huge scales: full weight everywhere, saturation
    write_all(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h0, 32'h0001_0000);
    send_vertex(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
    send_vertex(mk(32'h8000_0000, 32'h0000_0001, 32'h0001_0000, 1'b0));
    send_vertex(mk(32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 1'b0));
    wait_empty();
    // zero global weight passes everything through
    write_reg(REG_GLOBAL_WEIGHT, 32'h0);
    send_vertex(mk(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
    send_vertex(mk(32'h0, 32'h0, 32'h0, 1'b0));
    wait_empty();
    // weight above one, extreme centers and a small falloff
    write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0003_0000,
              32'hFFFE_0000, 32'h0000_0001, 32'h0000_4000, 32'hFFFF_FFFF);
    send_vertex(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    send_vertex(mk(32'h8001_0000, 32'h7FFE_0000, 32'h8000_4000, 1'b1));
    send_vertex(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    wait_empty();
    write_reg(REG_FALLOFF, 32'hFFFF_FFFF);
    send_vertex(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
    send_vertex(mk(32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    wait_empty();
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      write_all($urandom_range(0, 3) == 0 ? $urandom : 32'($signed($urandom) >>> 6),
                $urandom_range(0, 3) == 0 ? $urandom : 32'($signed($urandom) >>> 6),
                $urandom_range(0, 3) == 0 ? $urandom : 32'($signed($urandom) >>> 6),
                random_scale(), random_scale(), random_scale(),
                $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 32'h0002_0000),
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536));
      tx_idle = (p % 3) != 1;
      rx_idle = (p % 3) != 2;
      for (int i = 0; i < per_phase; i++) send_vertex(random_vertex());
      wait_empty();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_backpressure();
    tx_idle     = 1'b0;
    hold_toggle = ~hold_toggle;
    for (int i = 0; i < 120; i++) send_vertex(random_vertex());
    // pause mid-stream until everything drains, then continue
    wait_empty();
    for (int i = 0; i < 40; i++) send_vertex(random_vertex());
    tx_idle = 1'b1;
    wait_empty();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    hold_toggle = 1'b0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    cycles      = 0;
    mismatches  = 0;
    sent_cnt    = 0;
    got_cnt     = 0;
    cfg_cnt     = 0;
    for (int i = 0; i < 3; i++) begin
      cen[i] = 0;
      scl[i] = 65536;
    end
    fall_q = 64'd65536;
    gain_q = 64'd65536;
    exp_coef_q30[0] = sqrt_floor(64'd1 << 59);
    for (int j = 1; j < 16; j++) exp_coef_q30[j] = sqrt_floor(exp_coef_q30[j-1] << 30);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_directed();
    test_backpressure();
    test_random(6, 170);

    while (deformed_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d vertices in, %0d out, %0d register writes,", sent_cnt, got_cnt,
             cfg_cnt);
    $display("  including saturation, zero weight, zero falloff and a long output hold.");
    if (mismatches == 0 && deformed_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
